[rtl/rft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rft_pkg : repeat fingerprint table shared definitions
// Widths, codes and the beat that travels along the cell chain.
// ----------------------------------------------------------------------------
package rft_pkg;

  localparam int unsigned KEY_W             = 32;
  localparam int unsigned CNT_W             = 8;
  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_MAX     = '1;
  localparam logic [CNT_W-1:0] CNT_FREE    = '0;
  localparam logic [CNT_W-1:0] CNT_FIRST   = CNT_W'(1);

  typedef enum logic [1:0] {
    OUT_ZERO   = 2'd0,
    OUT_MATCH  = 2'd1,
    OUT_INSERT = 2'd2,
    OUT_PURGE  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_PURGE  = 2'd2
  } op_t;

  typedef struct packed {
    logic             vld;
    op_t              op;
    logic [KEY_W-1:0] ka;
    logic [KEY_W-1:0] kb;
    logic [KEY_W-1:0] kc;
    logic             done;
    logic             rep;
    logic             free_seen;
  } beat_t;

endpackage

[rtl/rft_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rft_cell : one table entry
// Holds one key and its hit count, acts on the passing beat, hands it on.
// ----------------------------------------------------------------------------
module rft_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [rft_pkg::CNT_W-1:0] limit,
  input  rft_pkg::beat_t            beat_i,
  output rft_pkg::beat_t            beat_o
);
  import rft_pkg::*;

  logic [KEY_W-1:0] ka_r, kb_r, kc_r;
  logic [KEY_W-1:0] ka_nxt, kb_nxt, kc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  beat_t            beat_r, beat_nxt;
  logic             hit;
  logic             is_free;

  assign is_free = (cnt_r == CNT_FREE);
  assign hit     = !is_free && (ka_r == beat_i.ka) && (kb_r == beat_i.kb) &&
                   (kc_r == beat_i.kc);

  always_comb begin
    ka_nxt   = ka_r;
    kb_nxt   = kb_r;
    kc_nxt   = kc_r;
    cnt_nxt  = cnt_r;
    beat_nxt = beat_i;
    if (beat_i.vld) begin
      case (beat_i.op)
        OP_SEARCH: begin
          if (is_free) begin
            beat_nxt.free_seen = 1'b1;
          end
          if (!beat_i.done && hit) begin
            beat_nxt.done = 1'b1;
            beat_nxt.rep  = (cnt_r >= limit);
            if (cnt_r != CNT_MAX) begin
              cnt_nxt = cnt_r + CNT_FIRST;
            end
          end
        end
        OP_INSERT: begin
          if (!beat_i.done && is_free) begin
            ka_nxt        = beat_i.ka;
            kb_nxt        = beat_i.kb;
            kc_nxt        = beat_i.kc;
            cnt_nxt       = CNT_FIRST;
            beat_nxt.done = 1'b1;
          end
        end
        OP_PURGE: begin
          if (cnt_r <= limit) begin
            cnt_nxt = CNT_FREE;
          end
        end
        default: begin
          beat_nxt = beat_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ka_r <= ka_nxt;
    kb_r <= kb_nxt;
    kc_r <= kc_nxt;
    if (!rst_n) begin
      cnt_r  <= CNT_FREE;
      beat_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      beat_r <= beat_nxt;
    end
  end

  assign beat_o = beat_r;

endmodule

[rtl/rft_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rft_seq : command sequencer
// Launches the search sweep, then an insert or purge sweep when no cell
// matched, and strobes the result; a zero key is answered without a sweep.
// ----------------------------------------------------------------------------
module rft_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [rft_pkg::KEY_W-1:0] key_a,
  input  logic signed [rft_pkg::KEY_W-1:0] key_b,
  input  logic signed [rft_pkg::KEY_W-1:0] key_c,
  output logic                             busy,
  output logic                             res_strobe,
  output logic                             res_is_repeat,
  output logic [1:0]                       res_outcome,
  output rft_pkg::beat_t                   head_o,
  input  rft_pkg::beat_t                   tail_i
);
  import rft_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_SWEEP  = 3'b100
  } state_t;

  state_t   state_r, state_nxt;
  beat_t    head_r, head_nxt;
  logic     strobe_r, strobe_nxt;
  logic     rep_r, rep_nxt;
  outcome_t outc_r, outc_nxt;
  outcome_t pend_r, pend_nxt;
  logic     key_zero;

  assign key_zero = (key_a == '0) && (key_b == '0) && (key_c == '0);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    head_nxt.vld = 1'b0;
    strobe_nxt   = 1'b0;
    rep_nxt      = rep_r;
    outc_nxt     = outc_r;
    pend_nxt     = pend_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (key_zero) begin
            strobe_nxt = 1'b1;
            rep_nxt    = 1'b0;
            outc_nxt   = OUT_ZERO;
          end else begin
            head_nxt.vld       = 1'b1;
            head_nxt.op        = OP_SEARCH;
            head_nxt.ka        = key_a;
            head_nxt.kb        = key_b;
            head_nxt.kc        = key_c;
            head_nxt.done      = 1'b0;
            head_nxt.rep       = 1'b0;
            head_nxt.free_seen = 1'b0;
            state_nxt          = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (tail_i.vld) begin
          if (tail_i.done) begin
            strobe_nxt = 1'b1;
            rep_nxt    = tail_i.rep;
            outc_nxt   = OUT_MATCH;
            state_nxt  = S_IDLE;
          end else begin
            head_nxt.vld  = 1'b1;
            head_nxt.done = 1'b0;
            head_nxt.op   = tail_i.free_seen ? OP_INSERT : OP_PURGE;
            pend_nxt      = tail_i.free_seen ? OUT_INSERT : OUT_PURGE;
            state_nxt     = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        if (tail_i.vld) begin
          strobe_nxt = 1'b1;
          rep_nxt    = 1'b0;
          outc_nxt   = pend_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rep_r  <= rep_nxt;
    outc_r <= outc_nxt;
    pend_r <= pend_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
      head_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      head_r   <= head_nxt;
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign head_o        = head_r;
  assign res_strobe    = strobe_r;
  assign res_is_repeat = rep_r;
  assign res_outcome   = outc_r;

endmodule

[rtl/repeat_fingerprint_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeat_fingerprint_table : repeat detector over message fingerprints
// Channel  | ports                                   | handshake
// input    | in_key_a, in_key_b, in_key_c            | start && !busy
// result   | out_is_repeat, out_outcome              | out_strobe, one cycle
// config   | cfg_data (repeat limit)                 | cfg_valid && cfg_ready
//
// A beat walks the row of TABLE_ENTRIES cells, one cell a cycle.
// Zero key: result strobed in the cycle after start, busy stays low.
// Match: result strobed as busy falls.
// Insert or purge: a second sweep, result strobed as busy falls.
// Reset clears every count; results cannot be stalled.
// ----------------------------------------------------------------------------
module repeat_fingerprint_table #(
  parameter int unsigned TABLE_ENTRIES = rft_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [rft_pkg::KEY_W-1:0] in_key_a,
  input  logic signed [rft_pkg::KEY_W-1:0] in_key_b,
  input  logic signed [rft_pkg::KEY_W-1:0] in_key_c,
  output logic                             out_strobe,
  output logic                             out_is_repeat,
  output logic [1:0]                       out_outcome,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rft_pkg::CNT_W-1:0]        cfg_data
);
  import rft_pkg::*;

  logic [CNT_W-1:0] limit_r;
  beat_t            chain [TABLE_ENTRIES+1];

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  rft_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .key_a         (in_key_a),
    .key_b         (in_key_b),
    .key_c         (in_key_c),
    .busy          (busy),
    .res_strobe    (out_strobe),
    .res_is_repeat (out_is_repeat),
    .res_outcome   (out_outcome),
    .head_o        (chain[0]),
    .tail_i        (chain[TABLE_ENTRIES])
  );

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    rft_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .limit  (limit_r),
      .beat_i (chain[i]),
      .beat_o (chain[i+1])
    );
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobed while busy");

  a_repeat_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_outcome != OUT_MATCH)) |-> !out_is_repeat)
    else $error("repeat flag on a non-match result");

  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a start");

  a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
    chain[TABLE_ENTRIES].vld |-> busy)
    else $error("beat left the row while idle");

endmodule

[tb/repeat_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeat_table_checker : verdict predictor and comparator
// Watches the key, verdict and limit channels of repeat_fingerprint_table.
// Keeps its own copy of the fingerprint table and repeat limit. Every
// accepted key beat queues the expected verdict, and each strobed verdict
// is checked against the oldest entry in that queue.
// ----------------------------------------------------------------------------
module repeat_table_checker #(
  parameter int unsigned TABLE_ENTRIES = rft_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [rft_pkg::KEY_W-1:0] in_key_a,
  input  logic [rft_pkg::KEY_W-1:0] in_key_b,
  input  logic [rft_pkg::KEY_W-1:0] in_key_c,
  input  logic                      out_strobe,
  input  logic                      out_is_repeat,
  input  logic [1:0]                out_outcome,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [rft_pkg::CNT_W-1:0] cfg_data,
  output int                        verdicts_pending,
  output int                        mismatch_count
);
  import rft_pkg::*;

  typedef struct {
    logic     rep;
    outcome_t oc;
  } verdict_t;

  logic [KEY_W-1:0] tab_a [TABLE_ENTRIES];
  logic [KEY_W-1:0] tab_b [TABLE_ENTRIES];
  logic [KEY_W-1:0] tab_c [TABLE_ENTRIES];
  logic [CNT_W-1:0] tab_cnt [TABLE_ENTRIES];
  logic [CNT_W-1:0] limit_q;
  verdict_t         verdict_q [$];
  int               err_cnt;

  function automatic void clear_entry(input int i);
    tab_a[i]   = '0;
    tab_b[i]   = '0;
    tab_c[i]   = '0;
    tab_cnt[i] = CNT_FREE;
  endfunction

  function automatic verdict_t lookup_fingerprint(input logic [KEY_W-1:0] a,
                                                  input logic [KEY_W-1:0] b,
                                                  input logic [KEY_W-1:0] c);
    verdict_t v;
    int       hit;
    int       free_idx;
    v.rep    = 1'b0;
    v.oc     = OUT_ZERO;
    hit      = -1;
    free_idx = -1;
    if (a == '0 && b == '0 && c == '0) return v;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && tab_a[i] == a && tab_b[i] == b && tab_c[i] == c) hit = i;
    end
    if (hit >= 0) begin
      v.rep = (tab_cnt[hit] >= limit_q);
      if (tab_cnt[hit] != CNT_MAX) tab_cnt[hit] = tab_cnt[hit] + 1'b1;
      v.oc = OUT_MATCH;
      return v;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (free_idx < 0 && tab_cnt[i] == CNT_FREE) free_idx = i;
    end
    if (free_idx >= 0) begin
      tab_a[free_idx]   = a;
      tab_b[free_idx]   = b;
      tab_c[free_idx]   = c;
      tab_cnt[free_idx] = CNT_FIRST;
      v.oc = OUT_INSERT;
    end else begin
      // full: drop the key, purge everything at or below the limit
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (tab_cnt[i] <= limit_q) clear_entry(i);
      end
      v.oc = OUT_PURGE;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) clear_entry(i);
      limit_q = LIMIT_RESET;
      verdict_q.delete();
      err_cnt = 0;
    end else begin
      if (out_strobe) begin
        if (verdict_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected verdict beat, expected none, actual rep=%0b oc=%0d",
                   $time, out_is_repeat, out_outcome);
        end else begin
          want = verdict_q.pop_front();
          if (out_is_repeat !== want.rep) begin
            err_cnt++;
            $display("%0t: is_repeat mismatch, expected %0b, actual %0b",
                     $time, want.rep, out_is_repeat);
          end
          if (out_outcome !== want.oc) begin
            err_cnt++;
            $display("%0t: outcome mismatch, expected %0d, actual %0d",
                     $time, want.oc, out_outcome);
          end
        end
      end
      if (cfg_valid && cfg_ready) limit_q = cfg_data;
      if (start && !busy) verdict_q.push_back(lookup_fingerprint(in_key_a, in_key_b, in_key_c));
    end
    verdicts_pending <= verdict_q.size();
    mismatch_count   <= err_cnt;
  end

endmodule

[tb/tb_repeat_fingerprint_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_repeat_fingerprint_table : top of the fingerprint table testbench
// Drives key beats in random bursts from a small key pool, so the table
// fills, repeats cross the limit and purges happen, under several repeat
// limits including 0, 254 and 255. Verdicts are checked by the checker.
// ----------------------------------------------------------------------------
module tb_repeat_fingerprint_table;
  import rft_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int POOL_SIZE      = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [KEY_W-1:0] in_key_a = '0;
  logic [KEY_W-1:0] in_key_b = '0;
  logic [KEY_W-1:0] in_key_c = '0;
  logic             out_strobe;
  logic             out_is_repeat;
  logic [1:0]       out_outcome;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;
  int               verdicts_pending;
  int               mismatch_count;
  int               idle_cycles = 0;

  logic [KEY_W-1:0] pool_a [POOL_SIZE];
  logic [KEY_W-1:0] pool_b [POOL_SIZE];
  logic [KEY_W-1:0] pool_c [POOL_SIZE];
  int               burst_left = 0;
  bit               no_gaps = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  repeat_fingerprint_table dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_key_a      (in_key_a),
    .in_key_b      (in_key_b),
    .in_key_c      (in_key_c),
    .out_strobe    (out_strobe),
    .out_is_repeat (out_is_repeat),
    .out_outcome   (out_outcome),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  repeat_table_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_key_a         (in_key_a),
    .in_key_b         (in_key_b),
    .in_key_c         (in_key_c),
    .out_strobe       (out_strobe),
    .out_is_repeat    (out_is_repeat),
    .out_outcome      (out_outcome),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .verdicts_pending (verdicts_pending),
    .mismatch_count   (mismatch_count)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_key(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b,
                          input logic [KEY_W-1:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 14);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start    <= 1'b1;
    in_key_a <= a;
    in_key_b <= b;
    in_key_c <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_key(output logic [KEY_W-1:0] a, output logic [KEY_W-1:0] b,
                          output logic [KEY_W-1:0] c);
    int roll;
    int slot;
    logic [KEY_W-1:0] w;
    roll = $urandom_range(0, 99);
    slot = $urandom_range(0, POOL_SIZE - 1);
    if (roll < 8) begin
      a = '0;
      b = '0;
      c = '0;
      return;
    end
    if (roll < 16) begin
      // sparse key: one word set, the others zero
      case ($urandom_range(0, 2))
        0:       w = '1;
        1:       w = {1'b1, {(KEY_W-1){1'b0}}};
        default: w = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
      endcase
      pool_a[slot] = '0;
      pool_b[slot] = '0;
      pool_c[slot] = '0;
      case ($urandom_range(0, 2))
        0:       pool_a[slot] = w;
        1:       pool_b[slot] = w;
        default: pool_c[slot] = w;
      endcase
    end else if (roll < 30) begin
      pool_a[slot] = $urandom;
      pool_b[slot] = $urandom;
      pool_c[slot] = $urandom;
    end
    a = pool_a[slot];
    b = pool_b[slot];
    c = pool_c[slot];
  endtask

  task automatic random_phase(input int n_items);
    int sent;
    int slot;
    int run_len;
    logic [KEY_W-1:0] a, b, c;
    sent    = 0;
    no_gaps = ($urandom_range(0, 2) == 0);
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 12) begin
        // hammer one pooled key to push its count past the limit
        slot    = $urandom_range(0, POOL_SIZE - 1);
        run_len = $urandom_range(2, 8);
        repeat (run_len) send_key(pool_a[slot], pool_b[slot], pool_c[slot]);
        sent += run_len;
      end else begin
        pick_key(a, b, c);
        send_key(a, b, c);
        sent++;
      end
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  initial begin
    logic [KEY_W-1:0] ha, hb, hc;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_a[i] = $urandom;
      pool_b[i] = $urandom;
      pool_c[i] = $urandom;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero key, extreme words, crossing the reset limit, fill and purge
    send_key('0, '0, '0);
    send_key('0, '0, 32'h0000_0001);
    send_key(32'h8000_0000, '0, '0);
    send_key('1, '1, '1);
    send_key(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    repeat (4) send_key('1, '1, '1);
    for (int i = 0; i < 12; i++) send_key(32'h1000 + i, 32'hA5A5_0000 ^ i, 32'h5A5A_FFFF);
    send_key(32'hDEAD_0001, 32'h0BAD_F00D, 32'h1234_5678);
    send_key('0, '0, 32'h0000_0001);

    random_phase(300);
    write_limit(CNT_W'(0));
    random_phase(300);

    // limit 255: counts saturate, only a saturated entry is flagged
    write_limit(CNT_MAX);
    ha = $urandom;
    hb = $urandom;
    hc = $urandom | 32'h1;
    no_gaps = 1'b1;
    repeat (264) send_key(ha, hb, hc);
    random_phase(150);

    write_limit(CNT_W'(254));
    random_phase(300);
    write_limit(CNT_W'($urandom_range(1, 253)));
    random_phase(300);
    write_limit(CNT_W'(1));
    random_phase(300);

    start <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rft_pkg.sv
rtl/rft_cell.sv
rtl/rft_seq.sv
rtl/repeat_fingerprint_table.sv
tb/repeat_table_checker.sv
tb/tb_repeat_fingerprint_table.sv
